[rtl/rpa_pkg.sv]
// shared constants, codes and helpers for the refcounted page allocator
package rpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_W     = 12;
  localparam int TOP_W      = $clog2(NUM_PAGES) + 1;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int COUNT_BITS = 8;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [PAGE_W-1:0]     FIRST_PAGE_RESET = PAGE_W'(64);
  localparam logic [TOP_W-1:0]      TOP_FULL = TOP_W'(NUM_PAGES);

  typedef logic [PAGE_W-1:0]     page_t;
  typedef logic [TOP_W-1:0]      top_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [REQ_W-1:0]      req_t;
  typedef logic [STATUS_W-1:0]   status_t;

  // request codes
  localparam req_t REQ_ALLOC = 3'd0;
  localparam req_t REQ_FREE  = 3'd1;
  localparam req_t REQ_INC   = 3'd2;
  localparam req_t REQ_DEC   = 3'd3;
  localparam req_t REQ_READ  = 3'd4;
  localparam req_t REQ_TOTAL = 3'd5;

  // status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_OOM    = 2'd1;
  localparam status_t ST_RANGE  = 2'd2;
  localparam status_t ST_DOUBLE = 2'd3;

  // number of usable pages for a given lowest page
  function automatic top_t usable_pages(input page_t first);
    top_t first_ext;
    first_ext = TOP_W'(first);
    if (first_ext < TOP_FULL) begin
      return TOP_FULL - first_ext;
    end
    return '0;
  endfunction

endpackage

[rtl/refcounted_page_allocator_unit.sv]
// top level of the refcounted page allocator: free stack and count memories
//
// usage: a request word (req_type, page) is taken at a clock edge where start
// is high and busy is low. the block reads both memories on that edge, works
// out the answer and writes back in the following cycle, and presents the result
// word (status, page_out, use_count, free_total) with done high for exactly
// one cycle right after that. busy stays high until the request is finished,
// so a new request is taken only after the previous one: first the synchronous
// read of the stack and count memories, then the modify and write-back.
// the receiver cannot stall; done is a one-cycle strobe.
// reset and every write of first_page (cfg_wen/cfg_wdata) start a clearing
// pass over all 4096 entries that zeroes all reference counts and rebuilds
// the free stack with first_page at the bottom and the highest page on top;
// busy stays high during the pass, and a first_page write restarts it. the
// user must write first_page only while idle; the block does not enforce this.
module refcounted_page_allocator_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  rpa_pkg::req_t   req_type,
  input  rpa_pkg::page_t  page,
  input  logic            cfg_wen,
  input  rpa_pkg::page_t  cfg_wdata,
  output logic            done,
  output rpa_pkg::status_t status,
  output rpa_pkg::page_t  page_out,
  output rpa_pkg::count_t use_count,
  output rpa_pkg::top_t   free_total
);
  import rpa_pkg::*;

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration and stack pointer
  page_t first_page;
  top_t  top;
  top_t  top_next;
  idx_t  clr_idx;

  // captured request
  req_t  req_q;
  page_t page_q;

  // memories, read data registered
  page_t  stack_mem [NUM_PAGES];
  count_t ref_mem   [NUM_PAGES];
  page_t  stack_rd;
  count_t ref_rd;

  // write ports
  logic   stack_we;
  idx_t   stack_waddr;
  page_t  stack_wdata;
  logic   ref_we;
  idx_t   ref_waddr;
  count_t ref_wdata;

  // result of the modify step
  status_t res_status;
  page_t   res_page;
  count_t  res_count;

  logic accept;
  logic in_range;
  top_t top_dec;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign top_dec = top - TOP_W'(1);

  // page must be at or above first_page and below the page count
  assign in_range = (page_q >= first_page) && (TOP_W'(page_q) < TOP_FULL);

  // synchronous reads: count of the addressed page and the top stack entry
  always_ff @(posedge clk) begin
    ref_rd   <= ref_mem[page[IDX_W-1:0]];
    stack_rd <= stack_mem[top_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
  end

  // modify step, also drives the write-back ports
  always_comb begin
    res_status  = ST_OK;
    res_page    = '0;
    res_count   = '0;
    top_next    = top;
    ref_we      = 1'b0;
    ref_waddr   = page_q[IDX_W-1:0];
    ref_wdata   = ref_rd;
    stack_we    = 1'b0;
    stack_waddr = top[IDX_W-1:0];
    stack_wdata = page_q;

    if (state == S_CLEAR) begin
      // zero counts and lay out the stack bottom-up from first_page
      ref_we      = 1'b1;
      ref_waddr   = clr_idx;
      ref_wdata   = '0;
      stack_we    = 1'b1;
      stack_waddr = clr_idx;
      stack_wdata = first_page + PAGE_W'(clr_idx);
    end else if (state == S_EXEC) begin
      if (req_q == REQ_ALLOC) begin
        if (top == '0) begin
          res_status = ST_OOM;
        end else begin
          // pop: the top entry was read on the accept edge
          top_next  = top_dec;
          res_page  = stack_rd;
          res_count = COUNT_ONE;
          ref_we    = 1'b1;
          ref_waddr = stack_rd[IDX_W-1:0];
          ref_wdata = COUNT_ONE;
        end
      end else if (req_q == REQ_FREE || req_q == REQ_INC ||
                   req_q == REQ_DEC || req_q == REQ_READ) begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else begin
          ref_we = 1'b1;
          priority if (req_q == REQ_FREE) begin
            if (ref_rd > COUNT_ONE) begin
              ref_wdata = ref_rd - COUNT_ONE;
            end else if (ref_rd == COUNT_ONE) begin
              ref_wdata = '0;
              // a full stack drops the push but still clears the count
              if (top < TOP_FULL) begin
                stack_we = 1'b1;
                top_next = top + TOP_W'(1);
              end
            end else begin
              res_status = ST_DOUBLE;
            end
          end else if (req_q == REQ_INC) begin
            if (ref_rd != COUNT_MAX) begin
              ref_wdata = ref_rd + COUNT_ONE;
            end
          end else if (req_q == REQ_DEC) begin
            if (ref_rd != '0) begin
              ref_wdata = ref_rd - COUNT_ONE;
            end
          end else begin
            ref_wdata = ref_rd;
          end
          res_count = ref_wdata;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        if (clr_idx == idx_t'(NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_wen) begin
      state_next = S_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      first_page <= FIRST_PAGE_RESET;
      top        <= usable_pages(FIRST_PAGE_RESET);
      clr_idx    <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      top   <= top_next;
      if (cfg_wen) begin
        first_page <= cfg_wdata;
        top        <= usable_pages(cfg_wdata);
        clr_idx    <= '0;
      end else if (state == S_CLEAR) begin
        clr_idx <= clr_idx + idx_t'(1);
      end
    end
  end

  // request capture and result word, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      page_q <= page;
    end
    if (state == S_EXEC) begin
      status     <= res_status;
      page_out   <= res_page;
      use_count  <= res_count;
      free_total <= top_next;
    end
  end

  // stack pointer never passes the page count
  assert property (@(posedge clk) disable iff (rst) top <= TOP_FULL)
    else $error("stack pointer above page count");

  // a result strobe always follows an execute cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_EXEC))
    else $error("result strobe without a request");

  // out of memory only when the stack is empty
  assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OOM) |-> (free_total == '0 && use_count == '0))
    else $error("out of memory with free pages left");

  // a pop lowers the stack by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && req_q == REQ_ALLOC && top != '0) |=> (top == $past(top) - TOP_W'(1)))
    else $error("alloc did not pop one page");

endmodule
